// ===== hw/rtl/iptq_pkg.sv =====
// Shared constants for the indexed priority task queue.
// Opcodes, fixed port widths and default sizes; no dependencies.
package iptq_pkg;

	// Fixed widths of the item fields
	localparam int OP_BITS       = 2;
	localparam int ID_BITS       = 6;
	localparam int PRIO_REQ_BITS = 16;
	localparam int PAY_REQ_BITS  = 32;

	// Default table geometry
	localparam int TASK_SLOTS_DEF    = 64;
	localparam int PRIORITY_BITS_DEF = 16;
	localparam int PAYLOAD_BITS_DEF  = 32;
	localparam int ENTRY_BITS_DEF    = 1 + PRIORITY_BITS_DEF + PAYLOAD_BITS_DEF;

	// Opcodes
	localparam logic [OP_BITS-1:0] OP_ADD    = 2'd0;
	localparam logic [OP_BITS-1:0] OP_UPDATE = 2'd1;
	localparam logic [OP_BITS-1:0] OP_POP    = 2'd2;
	localparam logic [OP_BITS-1:0] OP_QUERY  = 2'd3;

endpackage

// ===== hw/rtl/indexed_priority_task_queue.sv =====
// Indexed priority task queue: top level with sequencer, scan and result register.
// Depends on iptq_pkg and iptq_table.
//
// Tasks live in one RAM indexed by task id; each entry holds a valid mark,
// a signed priority and a payload tag. After reset the block clears every
// RAM slot in turn and holds in_stall high meanwhile. Add, update and query
// go through a RAM read, a modify/write and a result load. Pop reads every
// slot through the single RAM read port, one slot per cycle, then writes back
// the removed entry. Ties in priority go to the lowest id. One item is worked
// on at a time; a finished result sits in the output register so the next
// beat can be taken while it waits downstream.
module indexed_priority_task_queue #(
	parameter int TASK_SLOTS    = iptq_pkg::TASK_SLOTS_DEF,
	parameter int PRIORITY_BITS = iptq_pkg::PRIORITY_BITS_DEF,
	parameter int PAYLOAD_BITS  = iptq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// Request channel
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic [iptq_pkg::OP_BITS-1:0]             opcode,
	input  logic [iptq_pkg::ID_BITS-1:0]             task_id,
	input  logic signed [iptq_pkg::PRIO_REQ_BITS-1:0] priority_req,
	input  logic [iptq_pkg::PAY_REQ_BITS-1:0]        payload,
	// Result channel
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic                                     success,
	output logic [iptq_pkg::ID_BITS-1:0]             out_id,
	output logic signed [iptq_pkg::PRIO_REQ_BITS-1:0] out_priority,
	output logic [iptq_pkg::PAY_REQ_BITS-1:0]        out_payload
);

	import iptq_pkg::*;

	localparam int IDX_W   = $clog2(TASK_SLOTS);
	localparam int ENTRY_W = 1 + PRIORITY_BITS + PAYLOAD_BITS;
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TASK_SLOTS - 1);
	localparam logic [IDX_W:0]   SLOT_CNT  = (IDX_W + 1)'(TASK_SLOTS);

	// Sequencer states
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_LOOK  = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_POPWB = 3'd4;
	localparam logic [2:0] ST_PUSH  = 3'd5;

	logic [2:0]                      state_q;
	logic [IDX_W:0]                  scan_q;
	logic [IDX_W-1:0]                rd_idx_s1;

	// Latched request
	logic [OP_BITS-1:0]              op_q;
	logic [ID_BITS-1:0]              id_q;
	logic signed [PRIORITY_BITS-1:0] prio_q;
	logic [PAYLOAD_BITS-1:0]         pay_q;

	// Running best during a pop scan
	logic                            found_q;
	logic [IDX_W-1:0]                best_id_q;
	logic signed [PRIORITY_BITS-1:0] best_prio_q;
	logic [PAYLOAD_BITS-1:0]         best_pay_q;

	// Pending result and output register
	logic                            res_success_q;
	logic [ID_BITS-1:0]              res_id_q;
	logic signed [PRIO_REQ_BITS-1:0] res_prio_q;
	logic [PAY_REQ_BITS-1:0]         res_pay_q;
	logic                            out_valid_q;
	logic                            out_success_q;
	logic [ID_BITS-1:0]              out_id_q;
	logic signed [PRIO_REQ_BITS-1:0] out_prio_q;
	logic [PAY_REQ_BITS-1:0]         out_pay_q;

	// RAM ports
	logic                            mem_we;
	logic [IDX_W-1:0]                mem_waddr;
	logic [ENTRY_W-1:0]              mem_wdata;
	logic                            mem_re;
	logic [IDX_W-1:0]                mem_raddr;
	logic [ENTRY_W-1:0]              mem_rdata;

	logic                            rd_valid;
	logic signed [PRIORITY_BITS-1:0] rd_prio;
	logic [PAYLOAD_BITS-1:0]         rd_pay;
	logic                            in_range;
	logic                            accept;
	logic                            out_free;
	logic                            better;
	logic                            look_ok;

	iptq_table #(
		.DEPTH (TASK_SLOTS),
		.WIDTH (ENTRY_W)
	) u_table (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_en   (mem_re),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	// Entry layout: {valid, priority, payload}
	assign rd_valid = mem_rdata[ENTRY_W-1];
	assign rd_prio  = mem_rdata[ENTRY_W-2 -: PRIORITY_BITS];
	assign rd_pay   = mem_rdata[PAYLOAD_BITS-1:0];

	assign in_range = 32'(id_q) < 32'(TASK_SLOTS);
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Scan compare: strictly higher wins, so ties keep the lower id
	assign better = rd_valid && (!found_q || (rd_prio > best_prio_q));

	// Add succeeds on an absent id, update and query on a present one
	always_comb begin
		look_ok = 1'b0;
		if (in_range) begin
			if (op_q == OP_ADD) begin
				look_ok = !rd_valid;
			end else begin
				look_ok = rd_valid;
			end
		end
	end

	// RAM access control; reads and writes never land in the same cycle
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = scan_q[IDX_W-1:0];
			end
			ST_IDLE: begin
				if (accept) begin
					mem_re    = 1'b1;
					mem_raddr = (opcode == OP_POP) ? '0 : IDX_W'(task_id);
				end
			end
			ST_LOOK: begin
				mem_waddr = IDX_W'(id_q);
				if (look_ok && op_q == OP_ADD) begin
					mem_we    = 1'b1;
					mem_wdata = {1'b1, prio_q, pay_q};
				end else if (look_ok && op_q == OP_UPDATE) begin
					mem_we    = 1'b1;
					mem_wdata = {1'b1, prio_q, rd_pay};
				end
			end
			ST_SCAN: begin
				if (scan_q < SLOT_CNT) begin
					mem_re    = 1'b1;
					mem_raddr = scan_q[IDX_W-1:0];
				end
			end
			ST_POPWB: begin
				mem_we    = found_q;
				mem_waddr = best_id_q;
				mem_wdata = {1'b0, best_prio_q, best_pay_q};
			end
			ST_PUSH: begin
			end
			default: begin
			end
		endcase
	end

	// Address of the entry whose data shows up next cycle
	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_idx_s1 <= mem_raddr;
		end
	end

	// Request latch and scan best (payload registers)
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= opcode;
			id_q   <= task_id;
			prio_q <= PRIORITY_BITS'(priority_req);
			pay_q  <= PAYLOAD_BITS'(payload);
		end
		if (state_q == ST_SCAN && better) begin
			best_id_q   <= rd_idx_s1;
			best_prio_q <= rd_prio;
			best_pay_q  <= rd_pay;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			scan_q  <= '0;
			found_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (scan_q[IDX_W-1:0] == LAST_IDX) begin
						scan_q  <= '0;
						state_q <= ST_IDLE;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						found_q <= 1'b0;
						if (opcode == OP_POP) begin
							scan_q  <= (IDX_W + 1)'(1);
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_LOOK;
						end
					end
				end
				ST_LOOK: begin
					state_q <= ST_PUSH;
				end
				ST_SCAN: begin
					if (better) begin
						found_q <= 1'b1;
					end
					if (mem_re) begin
						scan_q <= scan_q + 1'b1;
					end
					if (rd_idx_s1 == LAST_IDX) begin
						state_q <= ST_POPWB;
					end
				end
				ST_POPWB: begin
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Pending result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_success_q <= 1'b0;
		end else if (state_q == ST_LOOK) begin
			res_success_q <= look_ok;
		end else if (state_q == ST_POPWB) begin
			res_success_q <= found_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOOK) begin
			res_id_q   <= '0;
			res_prio_q <= '0;
			res_pay_q  <= '0;
		end else if (state_q == ST_POPWB) begin
			res_id_q   <= found_q ? ID_BITS'(best_id_q) : '0;
			res_prio_q <= found_q ? PRIO_REQ_BITS'(best_prio_q) : '0;
			res_pay_q  <= found_q ? PAY_REQ_BITS'(best_pay_q) : '0;
		end
	end

	// Output register: a new beat loads, else a taken beat clears
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_PUSH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PUSH && out_free) begin
			out_success_q <= res_success_q;
			out_id_q      <= res_id_q;
			out_prio_q    <= res_prio_q;
			out_pay_q     <= res_pay_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign success      = out_success_q;
	assign out_id       = out_id_q;
	assign out_priority = out_prio_q;
	assign out_payload  = out_pay_q;

	// Checks
	a_no_rw_same_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("RAM read and write hit the same entry");

	a_scan_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !mem_we)
		else $error("RAM written during pop scan");

	a_pop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POPWB && found_q) |-> (mem_we && !mem_wdata[ENTRY_W-1]))
		else $error("popped entry not invalidated");

	a_out_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_PUSH))
		else $error("result beat raised outside push state");

endmodule

// ===== hw/rtl/iptq_table.sv =====
// Task table storage: one synchronous RAM, one write and one read port.
// Read data is registered. Uses iptq_pkg defaults.
module iptq_table #(
	parameter int DEPTH = iptq_pkg::TASK_SLOTS_DEF,
	parameter int WIDTH = iptq_pkg::ENTRY_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
